### rtl/pidc_pkg.sv
package pidc_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 47;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM  = 3'd4;

	// Input word: error sample (Q3.12) and time step (Q0.16 s)
	typedef struct packed {
		logic signed [15:0] error_value;
		logic [15:0]        time_step;
	} in_word_t;

	// Output word: drive and status flags
	typedef struct packed {
		logic signed [31:0] drive;
		logic               integral_clamped;
		logic               output_clamped;
		logic               zero_step;
	} out_word_t;

endpackage

### rtl/pid_controller_clamped.sv
// PID controller with integral clamp and output clamp.
//
// Input channel (in_valid/in_ready/in_data) takes one word per control
// sample: a signed Q3.12 error and an unsigned Q0.16 time step. Output
// channel (out_valid/out_ready/out_data) returns one word per sample: the
// signed 32-bit drive plus integral-clamped, output-clamped and zero-step
// flags. Gains and limits are to be written through cfg_we/cfg_index/
// cfg_wdata only while the block is idle; the block does not enforce this.
//
// A new word is taken only once the sequencer has finished the previous one.
// The derivative is formed by a 32-iteration radix-2 divider; the rest is
// one shared 16x25 multiplier feeding a 66-bit accumulator, steered by an
// 11-step microcode program.
//
// Reset clears gains, limits, the stored error and the integral. A finished
// word sits in the output register while the next word is processed; if the
// receiver is still stalling when the next result is ready, the sequencer
// holds on its last step until the output register frees up.
module pid_controller_clamped
	import pidc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Control word fields
	typedef enum logic [1:0] {MA_ERR, MA_KP, MA_KI, MA_KD} mul_a_t;
	typedef enum logic [2:0] {
		MB_DT, MB_ERR, MB_INT_HI, MB_INT_LO, MB_DER_HI, MB_DER_LO
	} mul_b_t;
	typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD} acc_op_t;
	typedef enum logic [1:0] {SH_0, SH_16, SH_24, SH_40} acc_sh_t;
	typedef enum logic [2:0] {
		OP_NONE, OP_DIV_INIT, OP_INTEG, OP_DIV_STEP, OP_DERIV, OP_FINISH
	} dp_op_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_DIV_LOOP, JMP_END} jmp_t;

	typedef struct packed {
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		acc_op_t acc_op;
		acc_sh_t acc_sh;
		dp_op_t  op;
		jmp_t    jmp;
	} ctrl_t;

	localparam int PC_W = 4;

	// Microcode ROM. A product selected in one step is accumulated in the next.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		unique case (pc)
			4'd0: cw = '{MA_ERR, MB_DT,     ACC_NONE, SH_0,  OP_DIV_INIT, JMP_NEXT};
			4'd1: cw = '{MA_KP,  MB_ERR,    ACC_NONE, SH_0,  OP_INTEG,    JMP_NEXT};
			4'd2: cw = '{MA_KI,  MB_INT_HI, ACC_LOAD, SH_16, OP_NONE,     JMP_NEXT};
			4'd3: cw = '{MA_KI,  MB_INT_LO, ACC_ADD,  SH_24, OP_NONE,     JMP_NEXT};
			4'd4: cw = '{MA_ERR, MB_DT,     ACC_ADD,  SH_0,  OP_NONE,     JMP_NEXT};
			4'd5: cw = '{MA_ERR, MB_DT,     ACC_NONE, SH_0,  OP_DIV_STEP, JMP_DIV_LOOP};
			4'd6: cw = '{MA_ERR, MB_DT,     ACC_NONE, SH_0,  OP_DERIV,    JMP_NEXT};
			4'd7: cw = '{MA_KD,  MB_DER_HI, ACC_NONE, SH_0,  OP_NONE,     JMP_NEXT};
			4'd8: cw = '{MA_KD,  MB_DER_LO, ACC_ADD,  SH_40, OP_NONE,     JMP_NEXT};
			4'd9: cw = '{MA_ERR, MB_DT,     ACC_ADD,  SH_16, OP_NONE,     JMP_NEXT};
			4'd10: cw = '{MA_ERR, MB_DT,    ACC_NONE, SH_0,  OP_FINISH,   JMP_END};
			default: cw = '{MA_ERR, MB_DT,  ACC_NONE, SH_0,  OP_NONE,     JMP_END};
		endcase
		return cw;
	endfunction

	// Configuration registers
	logic signed [15:0] kp_q, ki_q, kd_q;
	logic [46:0]        ilim_q;
	logic [30:0]        olim_q;

	// Sequencer
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [4:0]      div_cnt_q;
	ctrl_t           cw;
	logic            stall;
	logic            step_en;

	// Datapath registers
	logic signed [15:0] err_q;
	logic [15:0]        dt_q;
	logic signed [15:0] last_q;
	logic signed [47:0] integ_q;
	logic               iclamp_q;
	logic [15:0]        rem_q;
	logic [31:0]        quo_q;
	logic               neg_q;
	logic signed [32:0] deriv_q;
	logic signed [40:0] prod_s1;
	logic signed [65:0] acc_q;

	// Output register
	logic      out_valid_q;
	out_word_t out_q;

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cw      = ucode(pc_q);
	assign stall   = (cw.jmp == JMP_END) && out_valid_q && !out_ready;
	assign step_en = busy_q && !stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			ilim_q <= '0;
			olim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:    kp_q   <= cfg_wdata[15:0];
				REG_GAIN_I:    ki_q   <= cfg_wdata[15:0];
				REG_GAIN_D:    kd_q   <= cfg_wdata[15:0];
				REG_INTEG_LIM: ilim_q <= cfg_wdata;
				REG_OUT_LIM:   olim_q <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// Step counter and conditional jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
		end else if (step_en) begin
			case (cw.jmp)
				JMP_NEXT: pc_q <= pc_q + 1'b1;
				JMP_DIV_LOOP: begin
					if (div_cnt_q == '0)
						pc_q <= pc_q + 1'b1;
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

	// Shared multiplier operand select
	logic signed [15:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [40:0] prod;

	always_comb begin
		case (cw.mul_a)
			MA_KP:   mul_a = kp_q;
			MA_KI:   mul_a = ki_q;
			MA_KD:   mul_a = kd_q;
			default: mul_a = err_q;
		endcase
		case (cw.mul_b)
			MB_ERR:    mul_b = {{9{err_q[15]}}, err_q};
			MB_INT_HI: mul_b = {integ_q[47], integ_q[47:24]};
			MB_INT_LO: mul_b = {1'b0, integ_q[23:0]};
			MB_DER_HI: mul_b = {{16{deriv_q[32]}}, deriv_q[32:24]};
			MB_DER_LO: mul_b = {1'b0, deriv_q[23:0]};
			default:   mul_b = {9'd0, dt_q};
		endcase
	end

	assign prod = mul_a * mul_b;

	// Shifted product for the accumulator
	logic signed [65:0] prod_ext, prod_sh;

	always_comb begin
		prod_ext = {{25{prod_s1[40]}}, prod_s1};
		case (cw.acc_sh)
			SH_16:   prod_sh = prod_ext <<< 16;
			SH_24:   prod_sh = prod_ext <<< 24;
			SH_40:   prod_sh = prod_ext <<< 40;
			default: prod_sh = prod_ext;
		endcase
	end

	// Integral update: add error*dt, saturate to 48 bits, then apply limit
	logic signed [48:0] isum;
	logic signed [47:0] isat, ilim_pos, ilim_neg, inext;
	logic               isat_f, ilim_f;

	always_comb begin
		isum     = {integ_q[47], integ_q} + {{8{prod_s1[40]}}, prod_s1};
		isat_f   = 1'b0;
		isat     = isum[47:0];
		if (isum[48] != isum[47]) begin
			isat_f = 1'b1;
			isat   = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
		ilim_pos = {1'b0, ilim_q};
		ilim_neg = -ilim_pos;
		ilim_f   = 1'b0;
		inext    = isat;
		if (ilim_q != '0) begin
			if (isat > ilim_pos) begin
				inext  = ilim_pos;
				ilim_f = 1'b1;
			end else if (isat < ilim_neg) begin
				inext  = ilim_neg;
				ilim_f = 1'b1;
			end
		end
	end

	// Derivative numerator magnitude and one restoring divide step
	logic signed [16:0] diff, dmag;
	logic [16:0]        trial, tdiff;
	logic               take;
	logic [32:0]        qext;

	always_comb begin
		diff  = {err_q[15], err_q} - {last_q[15], last_q};
		dmag  = diff[16] ? -diff : diff;
		trial = {rem_q, quo_q[31]};
		tdiff = trial - {1'b0, dt_q};
		take  = trial >= {1'b0, dt_q};
		qext  = {1'b0, quo_q};
	end

	// Drive: floor to 16 fraction bits, saturate to 32 bits, apply limit
	logic signed [31:0] dsat, dnext, olim_pos, olim_neg;
	logic               dsat_f, dlim_f;

	always_comb begin
		dsat_f = 1'b0;
		dsat   = acc_q[51:20];
		if (acc_q[65:51] != {15{acc_q[51]}}) begin
			dsat_f = 1'b1;
			dsat   = acc_q[65] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end
		olim_pos = {1'b0, olim_q};
		olim_neg = -olim_pos;
		dlim_f   = 1'b0;
		dnext    = dsat;
		if (olim_q != '0) begin
			if (dsat > olim_pos) begin
				dnext  = olim_pos;
				dlim_f = 1'b1;
			end else if (dsat < olim_neg) begin
				dnext  = olim_neg;
				dlim_f = 1'b1;
			end
		end
	end

	// Controller state: stored error and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			integ_q <= '0;
		end else if (step_en && cw.op == OP_INTEG) begin
			last_q  <= err_q;
			integ_q <= inext;
		end
	end

	// Datapath working registers
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (in_valid && in_ready) begin
			err_q <= in_data.error_value;
			dt_q  <= in_data.time_step;
		end
		if (step_en) begin
			case (cw.acc_op)
				ACC_LOAD: acc_q <= prod_sh;
				ACC_ADD:  acc_q <= acc_q + prod_sh;
				default: ;
			endcase
			case (cw.op)
				OP_DIV_INIT: begin
					neg_q     <= diff[16];
					quo_q     <= {dmag[15:0], 16'd0};
					rem_q     <= '0;
					div_cnt_q <= 5'd31;
				end
				OP_INTEG: iclamp_q <= isat_f || ilim_f;
				OP_DIV_STEP: begin
					rem_q     <= take ? tdiff[15:0] : trial[15:0];
					quo_q     <= {quo_q[30:0], take};
					div_cnt_q <= div_cnt_q - 1'b1;
				end
				OP_DERIV: begin
					if (dt_q == '0)
						deriv_q <= '0;
					else
						deriv_q <= neg_q ? -qext : qext;
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && cw.op == OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && cw.op == OP_FINISH) begin
			out_q.drive            <= dnext;
			out_q.integral_clamped <= iclamp_q;
			out_q.output_clamped   <= dsat_f || dlim_f;
			out_q.zero_step        <= (dt_q == '0);
		end
	end

endmodule
